// ----- hdl/hcbd_pkg.sv -----
// Shared types, widths and helper functions for the chunked body decoder.
// No dependencies; used by the interfaces, hcbd_step and the top level.
package hcbd_pkg;

  localparam int unsigned BODY_W     = 41;
  localparam int unsigned LINE_W     = 17;
  localparam int unsigned LINE_SUM_W = LINE_W + 2;
  localparam int unsigned ACC_W      = BODY_W + 4;
  localparam int unsigned MAX_LINE_W = 16;
  localparam int unsigned MAX_BODY_W = 40;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [MAX_LINE_W-1:0] MAX_LINE_RST = MAX_LINE_W'(4096);
  localparam logic [MAX_BODY_W-1:0] MAX_BODY_RST = MAX_BODY_W'(16777216);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY = 1'b1;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF_A = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  typedef enum logic [5:0] {
    PH_SIZE     = 6'b000001,
    PH_EXT      = 6'b000010,
    PH_DATA     = 6'b000100,
    PH_CHUNK_CR = 6'b001000,
    PH_CHUNK_LF = 6'b010000,
    PH_TRAILER  = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_DATA  = 2'd1,
    ST_DONE  = 2'd2,
    ST_ERROR = 2'd3
  } status_e;

  typedef struct packed {
    phase_e              phase;
    logic [BODY_W-1:0]   chunk_size;
    logic                size_too_big;
    logic                digit_seen;
    logic                space_after_digits;
    logic                cr_pending;
    logic [LINE_W-1:0]   line_bytes;
    logic [LINE_W-1:0]   trailer_bytes;
    logic [LINE_W-1:0]   last_chunk_span;
    logic [BODY_W-1:0]   data_left;
    logic [BODY_W-1:0]   body_total;
    status_e             terminal;
  } dec_state_t;

  localparam dec_state_t STATE_RST = '{
    phase:              PH_SIZE,
    chunk_size:         '0,
    size_too_big:       1'b0,
    digit_seen:         1'b0,
    space_after_digits: 1'b0,
    cr_pending:         1'b0,
    line_bytes:         '0,
    trailer_bytes:      '0,
    last_chunk_span:    '0,
    data_left:          '0,
    body_total:         '0,
    terminal:           ST_MORE
  };

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= CH_0 && b <= CH_9) begin
      r = {1'b1, 4'(b - CH_0)};
    end else if (b >= CH_LA && b <= CH_LF_A) begin
      r = {1'b1, 4'(b - CH_LA + 8'd10)};
    end else if (b >= CH_UA && b <= CH_UF) begin
      r = {1'b1, 4'(b - CH_UA + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF) ||
           (b == CH_VT) || (b == CH_FF);
  endfunction

  function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] x);
    return (x == LINE_MAX) ? x : x + LINE_W'(1);
  endfunction

  function automatic logic [LINE_W-1:0] line_sat(input logic [LINE_SUM_W-1:0] x);
    return (x > LINE_SUM_W'(LINE_MAX)) ? LINE_MAX : x[LINE_W-1:0];
  endfunction

endpackage

// ----- hdl/hcbd_if.sv -----
// Valid/ready channel interfaces: input word, result word, register writes.
// Depends on hcbd_pkg for widths.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_out;
  modport source (output valid, status, data_out, input ready);
  modport sink   (input valid, status, data_out, output ready);
endinterface

interface hcbd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hcbd_pkg::CFG_IDX_W-1:0]   index;
  logic [hcbd_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/hcbd_step.sv -----
// Next-state and result logic for one decoder word.
// Depends on hcbd_pkg (state struct, phases, status codes, char helpers).
module hcbd_step (
  input  hcbd_pkg::dec_state_t                cur_i,
  input  logic                                command_i,
  input  logic [7:0]                          data_byte_i,
  input  logic [hcbd_pkg::MAX_LINE_W-1:0]     max_line_i,
  input  logic [hcbd_pkg::BODY_W-1:0]         limit_i,
  output hcbd_pkg::dec_state_t                nxt_o,
  output hcbd_pkg::status_e                   status_o,
  output logic [7:0]                          data_out_o
);

  always_comb begin
    hcbd_pkg::dec_state_t               nxt;
    hcbd_pkg::status_e                  st;
    logic [7:0]                         dout;
    logic [4:0]                         hex;
    logic [hcbd_pkg::ACC_W-1:0]         acc;
    logic [hcbd_pkg::LINE_W-1:0]        lb1;
    logic [hcbd_pkg::LINE_W-1:0]        lb2;
    logic                               sad1;
    logic [hcbd_pkg::LINE_SUM_W-1:0]    held;
    logic [hcbd_pkg::LINE_SUM_W-1:0]    tsum;
    logic [hcbd_pkg::LINE_W-1:0]        tsat;
    logic [hcbd_pkg::LINE_W-1:0]        max_line;

    nxt      = cur_i;
    st       = hcbd_pkg::ST_MORE;
    dout     = 8'd0;
    hex      = hcbd_pkg::hex_value(data_byte_i);
    acc      = {cur_i.chunk_size, 4'b0000} + hcbd_pkg::ACC_W'(hex[3:0]);
    lb1      = cur_i.line_bytes;
    lb2      = cur_i.line_bytes;
    sad1     = cur_i.space_after_digits;
    held     = '0;
    tsum     = '0;
    tsat     = '0;
    max_line = hcbd_pkg::LINE_W'(max_line_i);

    if (command_i) begin
      nxt = hcbd_pkg::STATE_RST;
    end else if (cur_i.terminal != hcbd_pkg::ST_MORE) begin
      st = cur_i.terminal;
    end else begin
      unique case (cur_i.phase)
        hcbd_pkg::PH_DATA: begin
          dout          = data_byte_i;
          st            = hcbd_pkg::ST_DATA;
          nxt.data_left = cur_i.data_left - hcbd_pkg::BODY_W'(1);
          if (cur_i.data_left == hcbd_pkg::BODY_W'(1)) begin
            nxt.phase = hcbd_pkg::PH_CHUNK_CR;
          end
        end
        hcbd_pkg::PH_CHUNK_CR: begin
          if (data_byte_i != hcbd_pkg::CH_CR) st = hcbd_pkg::ST_ERROR;
          else nxt.phase = hcbd_pkg::PH_CHUNK_LF;
        end
        hcbd_pkg::PH_CHUNK_LF: begin
          if (data_byte_i != hcbd_pkg::CH_LF) begin
            st = hcbd_pkg::ST_ERROR;
          end else begin
            nxt.phase              = hcbd_pkg::PH_SIZE;
            nxt.chunk_size         = '0;
            nxt.size_too_big       = 1'b0;
            nxt.digit_seen         = 1'b0;
            nxt.space_after_digits = 1'b0;
            nxt.cr_pending         = 1'b0;
            nxt.line_bytes         = '0;
          end
        end
        default: begin
          if (cur_i.cr_pending && data_byte_i == hcbd_pkg::CH_LF) begin
            // line end
            if (cur_i.phase == hcbd_pkg::PH_TRAILER) begin
              tsum = hcbd_pkg::LINE_SUM_W'(cur_i.trailer_bytes) +
                     hcbd_pkg::LINE_SUM_W'(cur_i.line_bytes) + hcbd_pkg::LINE_SUM_W'(2);
              tsat = hcbd_pkg::line_sat(tsum);
              nxt.cr_pending = 1'b0;
              if (cur_i.line_bytes == '0) begin
                st = hcbd_pkg::ST_DONE;
              end else if (cur_i.line_bytes > max_line || tsat > max_line) begin
                st = hcbd_pkg::ST_ERROR;
              end else begin
                nxt.trailer_bytes = tsat;
                nxt.line_bytes    = '0;
              end
            end else begin
              if (cur_i.line_bytes > max_line || !cur_i.digit_seen ||
                  cur_i.size_too_big) begin
                st = hcbd_pkg::ST_ERROR;
              end else if (cur_i.chunk_size > limit_i - cur_i.body_total) begin
                st = hcbd_pkg::ST_ERROR;
              end else begin
                nxt.last_chunk_span = hcbd_pkg::line_sat(
                    hcbd_pkg::LINE_SUM_W'(cur_i.line_bytes) + hcbd_pkg::LINE_SUM_W'(2));
                if (cur_i.chunk_size == '0) begin
                  nxt.phase         = hcbd_pkg::PH_TRAILER;
                  nxt.trailer_bytes = '0;
                end else begin
                  nxt.phase      = hcbd_pkg::PH_DATA;
                  nxt.data_left  = cur_i.chunk_size;
                  nxt.body_total = cur_i.body_total + cur_i.chunk_size;
                end
                nxt.chunk_size         = '0;
                nxt.size_too_big       = 1'b0;
                nxt.digit_seen         = 1'b0;
                nxt.space_after_digits = 1'b0;
                nxt.cr_pending         = 1'b0;
                nxt.line_bytes         = '0;
              end
            end
          end else begin
            // a held CR that is not part of CR LF counts as whitespace
            if (cur_i.cr_pending) begin
              lb1  = hcbd_pkg::line_inc(cur_i.line_bytes);
              sad1 = cur_i.space_after_digits ||
                     (cur_i.phase == hcbd_pkg::PH_SIZE && cur_i.digit_seen);
            end
            nxt.space_after_digits = sad1;
            nxt.cr_pending         = 1'b0;
            lb2                    = lb1;
            if (data_byte_i == hcbd_pkg::CH_CR) begin
              nxt.cr_pending = 1'b1;
            end else begin
              lb2 = hcbd_pkg::line_inc(lb1);
              if (cur_i.phase == hcbd_pkg::PH_SIZE) begin
                if (hex[4]) begin
                  if (sad1) st = hcbd_pkg::ST_ERROR;
                  nxt.digit_seen = 1'b1;
                  if (!cur_i.size_too_big) begin
                    if (acc > hcbd_pkg::ACC_W'(limit_i)) nxt.size_too_big = 1'b1;
                    else nxt.chunk_size = acc[hcbd_pkg::BODY_W-1:0];
                  end
                end else if (hcbd_pkg::is_space(data_byte_i)) begin
                  nxt.space_after_digits = sad1 || cur_i.digit_seen;
                end else if (data_byte_i == hcbd_pkg::CH_SEMI) begin
                  nxt.phase = hcbd_pkg::PH_EXT;
                end else begin
                  st = hcbd_pkg::ST_ERROR;
                end
              end
            end
            nxt.line_bytes = lb2;
            held = hcbd_pkg::LINE_SUM_W'(lb2) + hcbd_pkg::LINE_SUM_W'(nxt.cr_pending);
            if (cur_i.phase == hcbd_pkg::PH_TRAILER) begin
              held = held + hcbd_pkg::LINE_SUM_W'(cur_i.last_chunk_span) +
                     hcbd_pkg::LINE_SUM_W'(cur_i.trailer_bytes);
            end
            if (held > hcbd_pkg::LINE_SUM_W'(max_line_i)) st = hcbd_pkg::ST_ERROR;
          end
        end
      endcase
      if (st == hcbd_pkg::ST_DONE || st == hcbd_pkg::ST_ERROR) nxt.terminal = st;
    end

    nxt_o      = nxt;
    status_o   = st;
    data_out_o = dout;
  end

endmodule

// ----- hdl/http_chunked_body_decoder_core.sv -----
// HTTP/1.1 chunked body decoder top level: channel registers, limits, state.
// Depends on hcbd_pkg, hcbd_if.sv interfaces and hcbd_step.
//
// Usage:
//   item_i   : one word per byte; command 0 feeds data_byte, 1 restarts the
//              decoder for a new body.
//   result_o : exactly one word per input word: status (0 need more, 1 data
//              byte in data_out, 2 done, 3 error) and data_out.
//   cfg_i    : register writes, index 0 max_line_bytes, 1 max_body_bytes;
//              always ready, write only while no word is in flight.
// A word is held in the input register after its handshake, then the decode
// logic loads the result register. Throughput is one word per cycle while
// the receiver takes results; the single decode stage between the two
// registers updates the parse state as each word moves on.
// When the receiver stalls the result register holds, the input register
// takes one more word, then ready drops until the result is taken.
// Reset empties both registers, returns the parser to the start of a size
// line and loads the limits with 4096 and 16777216.
module http_chunked_body_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    item_i,
  hcbd_out_if.source result_o,
  hcbd_cfg_if.sink   cfg_i
);

  logic [hcbd_pkg::MAX_LINE_W-1:0] max_line_q;
  logic [hcbd_pkg::MAX_BODY_W-1:0] max_body_q;
  logic                            in_vld_q;
  logic                            cmd_q;
  logic [7:0]                      byte_q;
  logic                            out_vld_q;
  logic [1:0]                      status_q;
  logic [7:0]                      data_q;
  hcbd_pkg::dec_state_t            state_q;
  hcbd_pkg::dec_state_t            state_d;
  hcbd_pkg::status_e               status_d;
  logic [7:0]                      data_d;
  logic                            move;
  logic                            take;

  assign move          = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready  = !in_vld_q || move;
  assign take          = item_i.valid && item_i.ready;
  assign cfg_i.ready   = 1'b1;

  assign result_o.valid    = out_vld_q;
  assign result_o.status   = status_q;
  assign result_o.data_out = data_q;

  hcbd_step u_step (
    .cur_i       (state_q),
    .command_i   (cmd_q),
    .data_byte_i (byte_q),
    .max_line_i  (max_line_q),
    .limit_i     (hcbd_pkg::BODY_W'(max_body_q)),
    .nxt_o       (state_d),
    .status_o    (status_d),
    .data_out_o  (data_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= hcbd_pkg::MAX_LINE_RST;
      max_body_q <= hcbd_pkg::MAX_BODY_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        hcbd_pkg::CFG_MAX_LINE: max_line_q <= cfg_i.data[hcbd_pkg::MAX_LINE_W-1:0];
        hcbd_pkg::CFG_MAX_BODY: max_body_q <= cfg_i.data[hcbd_pkg::MAX_BODY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= hcbd_pkg::STATE_RST;
    end else begin
      if (take) in_vld_q <= 1'b1;
      else if (move) in_vld_q <= 1'b0;
      if (move) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q  <= item_i.command;
      byte_q <= item_i.data_byte;
    end
    if (move) begin
      status_q <= status_d;
      data_q   <= data_d;
    end
  end

`ifndef SYNTHESIS
  a_terminal_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && !cmd_q && state_q.terminal != hcbd_pkg::ST_MORE)
      |=> (state_q.terminal == $past(state_q.terminal)))
    else $error("done/error state changed without restart");

  a_restart_answers_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && cmd_q) |=> (out_vld_q && status_q == hcbd_pkg::ST_MORE &&
                         state_q.phase == hcbd_pkg::PH_SIZE))
    else $error("restart did not return need-more and size phase");

  a_data_only_with_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q != hcbd_pkg::ST_DATA) |-> (data_q == 8'd0))
    else $error("data_out nonzero without data status");

  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !move) |=> (in_vld_q && $stable(cmd_q) && $stable(byte_q)))
    else $error("stalled input word lost");
`endif

endmodule

// ----- verif/http_chunked_body_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for http_chunked_body_decoder_core: a directed body, then random chunked bodies, noise and register
// settings, with every result word checked against an in-bench decoder model.
// Depends on hcbd_pkg, the hcbd_if.sv interfaces and the RTL under hdl/.
module http_chunked_body_decoder_core_tb;

  localparam logic CMD_FEED    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;
  localparam int   LIMIT       = 500000;
  localparam logic [63:0] LINE_TOP = (64'd1 << hcbd_pkg::LINE_W) - 64'd1;
  localparam logic [63:0] BODY_TOP = (64'd1 << hcbd_pkg::BODY_W) - 64'd1;

  typedef struct packed {
    hcbd_pkg::status_e status;
    logic [7:0]        data;
  } dec_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hcbd_in_if  item_if ();
  hcbd_out_if res_if ();
  hcbd_cfg_if cfg_if ();

  http_chunked_body_decoder_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // decoder model state
  logic [hcbd_pkg::MAX_LINE_W-1:0] lim_line;
  logic [hcbd_pkg::MAX_BODY_W-1:0] lim_body;
  hcbd_pkg::phase_e                p_phase;
  logic [hcbd_pkg::BODY_W-1:0]     p_size;
  logic                            p_size_ovf;
  logic                            p_have_digit;
  logic                            p_ws_after;
  logic                            p_cr_held;
  logic [hcbd_pkg::LINE_W-1:0]     p_line_cnt;
  logic [hcbd_pkg::LINE_W-1:0]     p_trl_cnt;
  logic [hcbd_pkg::LINE_W-1:0]     p_span;
  logic [hcbd_pkg::BODY_W-1:0]     p_remain;
  logic [hcbd_pkg::BODY_W-1:0]     p_total;
  hcbd_pkg::status_e               p_final;

  dec_word_t  decoded_q[$];
  dec_word_t  head;
  logic [7:0] stream_q[$];
  int         idle_pct = 13;
  int         fed_bytes;
  int         mismatches;
  int         cycles;

  function automatic logic [63:0] sat_line(input logic [63:0] v);
    return (v > LINE_TOP) ? LINE_TOP : v;
  endfunction

  function automatic logic [63:0] body_cap();
    return (64'(lim_body) > BODY_TOP) ? BODY_TOP : 64'(lim_body);
  endfunction

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= hcbd_pkg::CH_0 && b <= hcbd_pkg::CH_9) return int'(b - hcbd_pkg::CH_0);
    if (b >= hcbd_pkg::CH_LA && b <= hcbd_pkg::CH_LF_A) return int'(b - hcbd_pkg::CH_LA) + 10;
    if (b >= hcbd_pkg::CH_UA && b <= hcbd_pkg::CH_UF) return int'(b - hcbd_pkg::CH_UA) + 10;
    return -1;
  endfunction

  function automatic logic blank_char(input logic [7:0] b);
    return b == hcbd_pkg::CH_SP || b == hcbd_pkg::CH_TAB || b == hcbd_pkg::CH_CR ||
           b == hcbd_pkg::CH_LF || b == hcbd_pkg::CH_VT || b == hcbd_pkg::CH_FF;
  endfunction

  function automatic void clear_size_line();
    p_size       = '0;
    p_size_ovf   = 1'b0;
    p_have_digit = 1'b0;
    p_ws_after   = 1'b0;
    p_cr_held    = 1'b0;
    p_line_cnt   = '0;
  endfunction

  function automatic void reset_parser();
    p_phase = hcbd_pkg::PH_SIZE;
    clear_size_line();
    p_trl_cnt = '0;
    p_span    = '0;
    p_remain  = '0;
    p_total   = '0;
    p_final   = hcbd_pkg::ST_MORE;
  endfunction

  // one content byte of a line; 0 means a syntax error
  function automatic logic take_line_byte(input logic [7:0] b);
    int d;
    logic [63:0] v;
    p_line_cnt = hcbd_pkg::LINE_W'(sat_line(64'(p_line_cnt) + 64'd1));
    if (p_phase != hcbd_pkg::PH_SIZE) return 1'b1;
    d = hex_digit(b);
    if (d >= 0) begin
      if (p_ws_after) return 1'b0;
      p_have_digit = 1'b1;
      if (!p_size_ovf) begin
        v = 64'(p_size) * 64'd16 + 64'(d);
        if (v > body_cap()) p_size_ovf = 1'b1;
        else p_size = v[hcbd_pkg::BODY_W-1:0];
      end
      return 1'b1;
    end
    if (blank_char(b)) begin
      if (p_have_digit) p_ws_after = 1'b1;
      return 1'b1;
    end
    if (b == hcbd_pkg::CH_SEMI) begin
      p_phase = hcbd_pkg::PH_EXT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic hcbd_pkg::status_e line_done();
    if (p_phase == hcbd_pkg::PH_TRAILER) begin
      if (p_line_cnt == 0) return hcbd_pkg::ST_DONE;
      if (p_line_cnt > lim_line) return hcbd_pkg::ST_ERROR;
      p_trl_cnt = hcbd_pkg::LINE_W'(sat_line(64'(p_trl_cnt) + 64'(p_line_cnt) + 64'd2));
      if (p_trl_cnt > lim_line) return hcbd_pkg::ST_ERROR;
      p_line_cnt = '0;
      return hcbd_pkg::ST_MORE;
    end
    if (p_line_cnt > lim_line || !p_have_digit || p_size_ovf) return hcbd_pkg::ST_ERROR;
    if (64'(p_size) > body_cap() - 64'(p_total)) return hcbd_pkg::ST_ERROR;
    p_span = hcbd_pkg::LINE_W'(sat_line(64'(p_line_cnt) + 64'd2));
    if (p_size == 0) begin
      p_phase   = hcbd_pkg::PH_TRAILER;
      p_trl_cnt = '0;
    end else begin
      p_phase  = hcbd_pkg::PH_DATA;
      p_remain = p_size;
      p_total  = p_total + p_size;
    end
    clear_size_line();
    return hcbd_pkg::ST_MORE;
  endfunction

  function automatic hcbd_pkg::status_e feed_byte(input logic [7:0] b,
                                                  output logic [7:0] dout);
    logic [63:0] held;
    dout = '0;
    case (p_phase)
      hcbd_pkg::PH_DATA: begin
        dout     = b;
        p_remain = p_remain - 1'b1;
        if (p_remain == 0) p_phase = hcbd_pkg::PH_CHUNK_CR;
        return hcbd_pkg::ST_DATA;
      end
      hcbd_pkg::PH_CHUNK_CR: begin
        if (b != hcbd_pkg::CH_CR) return hcbd_pkg::ST_ERROR;
        p_phase = hcbd_pkg::PH_CHUNK_LF;
        return hcbd_pkg::ST_MORE;
      end
      hcbd_pkg::PH_CHUNK_LF: begin
        if (b != hcbd_pkg::CH_LF) return hcbd_pkg::ST_ERROR;
        p_phase = hcbd_pkg::PH_SIZE;
        clear_size_line();
        return hcbd_pkg::ST_MORE;
      end
      default: ;
    endcase
    if (p_cr_held) begin
      p_cr_held = 1'b0;
      if (b == hcbd_pkg::CH_LF) return line_done();
      if (!take_line_byte(hcbd_pkg::CH_CR)) return hcbd_pkg::ST_ERROR;
    end
    if (b == hcbd_pkg::CH_CR) p_cr_held = 1'b1;
    else if (!take_line_byte(b)) return hcbd_pkg::ST_ERROR;
    held = 64'(p_line_cnt) + 64'(p_cr_held);
    if (p_phase == hcbd_pkg::PH_TRAILER) held = held + 64'(p_span) + 64'(p_trl_cnt);
    if (held > 64'(lim_line)) return hcbd_pkg::ST_ERROR;
    return hcbd_pkg::ST_MORE;
  endfunction

  function automatic void decode_byte(input logic cmd, input logic [7:0] b,
                                      output hcbd_pkg::status_e st,
                                      output logic [7:0] dout);
    dout = '0;
    if (cmd == CMD_RESTART) begin
      reset_parser();
      st = hcbd_pkg::ST_MORE;
    end else if (p_final != hcbd_pkg::ST_MORE) begin
      st = p_final;
    end else begin
      st = feed_byte(b, dout);
      if (st == hcbd_pkg::ST_DONE || st == hcbd_pkg::ST_ERROR) p_final = st;
    end
    if (st != hcbd_pkg::ST_DATA) dout = '0;
  endfunction

  // stream building
  function automatic void put_byte(input logic [7:0] b);
    stream_q.push_back(b);
  endfunction

  function automatic void put_crlf();
    stream_q.push_back(hcbd_pkg::CH_CR);
    stream_q.push_back(hcbd_pkg::CH_LF);
  endfunction

  function automatic void put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0: return hcbd_pkg::CH_SP;
      1: return hcbd_pkg::CH_TAB;
      2: return hcbd_pkg::CH_VT;
      3: return hcbd_pkg::CH_FF;
      4: return hcbd_pkg::CH_LF;
      default: return hcbd_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return hcbd_pkg::CH_0 + 8'(n);
    return ($urandom_range(1) ? hcbd_pkg::CH_LA : hcbd_pkg::CH_UA) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(1)) return 8'($urandom);
    case ($urandom_range(9))
      0: return hcbd_pkg::CH_CR;
      1: return hcbd_pkg::CH_LF;
      2: return hcbd_pkg::CH_SP;
      3: return hcbd_pkg::CH_SEMI;
      4: return hcbd_pkg::CH_0;
      5: return hcbd_pkg::CH_9;
      6: return hcbd_pkg::CH_LF_A;
      7: return hcbd_pkg::CH_UF;
      8: return 8'h47;
      default: return 8'h3A;
    endcase
  endfunction

  function automatic void put_size_line(input logic [63:0] val, input int ndig);
    int i;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) put_byte(pick_blank());
    for (i = ndig - 1; i >= 0; i--) begin
      put_byte(hex_char(val[i*4 +: 4]));
      if (i > 0 && $urandom_range(39) == 0) put_byte(hcbd_pkg::CH_SP);
    end
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 2))
        put_byte($urandom_range(1) ? hcbd_pkg::CH_SP : hcbd_pkg::CH_TAB);
    if ($urandom_range(3) == 0) begin
      put_byte(hcbd_pkg::CH_SEMI);
      repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(8'h20, 8'h7E)));
    end
    put_crlf();
  endfunction

  function automatic void build_body();
    int k, sz;
    logic [63:0] big;
    stream_q.delete();
    for (k = $urandom_range(3); k > 0; k--) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: sz = $urandom_range(1, 8);
        7, 8: sz = $urandom_range(9, 40);
        default: begin
          // far too large to finish: send a few data bytes and stop
          big = {$urandom, $urandom} >> $urandom_range(20, 28);
          put_size_line(big, 11);
          repeat ($urandom_range(0, 12)) put_byte(8'($urandom));
          return;
        end
      endcase
      put_size_line(64'(sz), (sz < 16 ? 1 : 2) + $urandom_range(2));
      repeat (sz) put_byte(8'($urandom));
      put_crlf();
    end
    put_size_line(64'd0, 1 + $urandom_range(2));
    repeat ($urandom_range(3)) begin
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(8'h21, 8'h7E)));
      put_crlf();
    end
    put_crlf();
  endfunction

  function automatic void build_noise();
    stream_q.delete();
    repeat ($urandom_range(2, 20)) put_byte(noise_byte());
  endfunction

  function automatic void mutate_stream();
    int pos;
    if (stream_q.size() == 0) return;
    pos = $urandom_range(stream_q.size() - 1);
    case ($urandom_range(3))
      0: stream_q[pos] = noise_byte();
      1: stream_q.insert(pos, noise_byte());
      2: stream_q.delete(pos);
      default: while (stream_q.size() > pos) void'(stream_q.pop_back());
    endcase
  endfunction

  // driving
  task automatic send_word(input logic cmd, input logic [7:0] b);
    hcbd_pkg::status_e st;
    logic [7:0]        d;
    if ($urandom_range(99) < idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    item_if.valid     <= 1'b1;
    item_if.command   <= cmd;
    item_if.data_byte <= b;
    do @(posedge clk_i); while (!item_if.ready);
    fed_bytes++;
    decode_byte(cmd, b, st, d);
    decoded_q.push_back('{status: st, data: d});
  endtask

  task automatic send_stream();
    int i;
    send_word(CMD_RESTART, 8'($urandom));
    for (i = 0; i < stream_q.size(); i++) send_word(CMD_FEED, stream_q[i]);
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  task automatic write_reg(input logic [hcbd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hcbd_pkg::CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == hcbd_pkg::CFG_MAX_LINE) lim_line = val[hcbd_pkg::MAX_LINE_W-1:0];
    else lim_body = val[hcbd_pkg::MAX_BODY_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [hcbd_pkg::MAX_LINE_W-1:0] line_lim,
                            input logic [hcbd_pkg::MAX_BODY_W-1:0] body_lim);
    drain_results();
    repeat (4) @(posedge clk_i);
    // upper data bits are junk for the line limit register
    write_reg(hcbd_pkg::CFG_MAX_LINE, {24'($urandom), line_lim});
    write_reg(hcbd_pkg::CFG_MAX_BODY, body_lim);
  endtask

  task automatic feed_random_bodies(input int n);
    int target, sel;
    target = fed_bytes + n;
    while (fed_bytes < target) begin
      if ($urandom_range(19) == 0) drain_results();
      sel = $urandom_range(9);
      if (sel == 0) begin
        build_noise();
      end else begin
        build_body();
        if (sel <= 2) mutate_stream();
      end
      send_stream();
      if ($urandom_range(3) == 0) send_word(CMD_FEED, 8'($urandom));
    end
  endtask

  // tests
  task automatic test_directed_body();
    stream_q.delete();
    put_text(" 2 ;e");
    put_crlf();
    put_byte(8'h00);
    put_byte(8'hFF);
    put_crlf();
    put_text("0");
    put_crlf();
    put_text("X:1");
    put_crlf();
    put_crlf();
    put_byte(8'h7A);
    send_stream();
    send_word(CMD_RESTART, 8'h00);
    drain_results();
  endtask

  task automatic test_default_limits();
    feed_random_bodies(200);
  endtask

  task automatic test_widest_limits();
    set_limits(16'hFFFF, 40'hFF_FFFF_FFFF);
    feed_random_bodies(200);
  endtask

  task automatic test_narrowest_limits();
    set_limits(16'd1, 40'd0);
    feed_random_bodies(100);
  endtask

  task automatic test_tight_limits_no_idle();
    set_limits(16'd24, 40'd40);
    idle_pct = 0;
    feed_random_bodies(220);
    idle_pct = 13;
  endtask

  task automatic test_random_limits();
    set_limits(16'($urandom_range(6, 200)), 40'($urandom_range(0, 300)));
    feed_random_bodies(220);
  endtask

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d data %02h", res_if.status, res_if.data_out);
      end else begin
        head = decoded_q.pop_front();
        if (res_if.status !== head.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("status mismatch: expected %0d, got %0d", head.status, res_if.status);
        end
        if (res_if.data_out !== head.data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("data_out mismatch: expected %02h, got %02h", head.data, res_if.data_out);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    item_if.valid     = 1'b0;
    item_if.command   = CMD_FEED;
    item_if.data_byte = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = hcbd_pkg::CFG_MAX_LINE;
    cfg_if.data       = '0;
    lim_line          = hcbd_pkg::MAX_LINE_RST;
    lim_body          = hcbd_pkg::MAX_BODY_RST;
    reset_parser();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_body();
    test_default_limits();
    test_widest_limits();
    test_narrowest_limits();
    test_tight_limits_no_idle();
    test_random_limits();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
